// ===== design/smdf_pkg.sv =====
`timescale 1ns / 1ps

package smdf_pkg;

  // Field widths
  localparam int PIX_W   = 8;
  localparam int CFG_W   = 12;
  localparam int TOTAL_W = 31;
  localparam int MEAN_W  = 17;
  localparam int FRAC_W  = 8;

  // Dividend of the mean: total with the fraction bits appended
  localparam int DIVIDEND_W = TOTAL_W + FRAC_W;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;

  // Frame size limits and reset value
  localparam int SIZE_MIN   = 2;
  localparam int SIZE_RESET = 2048;

  localparam int DEF_MAX_WIDTH  = 2048;
  localparam int DEF_MAX_HEIGHT = 2048;

  // Saturation limit of the running total
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

endpackage

// ===== design/smdf_if.sv =====
`timescale 1ns / 1ps

// Pixel request channel
interface smdf_pixel_if import smdf_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel;

  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

// Frame result channel
interface smdf_result_if import smdf_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [TOTAL_W-1:0] total_difference;
  logic [MEAN_W-1:0]  mean_difference;

  modport source (output valid, output total_difference, output mean_difference, input ready);
  modport sink   (input valid, input total_difference, input mean_difference, output ready);
endinterface

// Configuration write channel
interface smdf_cfg_if import smdf_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== design/smdf_ram.sv =====
`timescale 1ns / 1ps

module smdf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  // Write one entry
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== design/sum_modulus_difference_focus_top.sv =====
`timescale 1ns / 1ps

// Sum-modulus-difference focus measure over one greyscale frame.
// pixel_i takes 8-bit pixels in raster order; a pixel is taken when valid and
// ready are both high. Each pixel adds its absolute difference to the left and
// to the upper neighbor, with mirrored borders at column 0 and row 0.
// cfg_i writes frame_width (index 0) or frame_height (index 1); a write
// restarts the frame, sizes are clamped to 2..MAX_WIDTH / 2..MAX_HEIGHT.
// result_o gives one request per frame: the total and the mean per pixel with
// 8 fraction bits.
// Throughput: one pixel per cycle within a frame. The previous row lives in a
// one-port-write, one-port-read RAM read in the cycle before the accumulate.
// After the last pixel the mean comes from a bit-serial divider; pixel_i.ready
// drops once that pixel has passed the accumulate stage and the divider has
// started, and stays low until that result moves to the output register, so
// the next frame waits for the division.
// A stalled receiver holds the result in the output register; the next frame
// streams in meanwhile, and only its own division waits for the register.
// Reset clears position, total and sizes (2048 each, clamped); the row RAM
// is not cleared, since row 0 never reads it.
module sum_modulus_difference_focus_top import smdf_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  smdf_pixel_if.sink    pixel_i,
  smdf_result_if.source result_o,
  smdf_cfg_if.sink      cfg_i
);

  localparam int CW     = $clog2(MAX_WIDTH);
  localparam int RW     = $clog2(MAX_HEIGHT);
  localparam int WW     = $clog2(MAX_WIDTH + 1);
  localparam int HW     = $clog2(MAX_HEIGHT + 1);
  localparam int CNT_W  = WW + HW;
  localparam int ADD_W  = PIX_W + 2;
  localparam int STEP_W = $clog2(DIVIDEND_W + 1);

  localparam logic [WW-1:0] RST_W =
    WW'((MAX_WIDTH < SIZE_RESET) ? MAX_WIDTH : SIZE_RESET);
  localparam logic [HW-1:0] RST_H =
    HW'((MAX_HEIGHT < SIZE_RESET) ? MAX_HEIGHT : SIZE_RESET);

  // Divider states
  localparam logic [1:0] DIV_IDLE = 2'd0;
  localparam logic [1:0] DIV_RUN  = 2'd1;
  localparam logic [1:0] DIV_DONE = 2'd2;

  typedef struct packed {
    logic             last;
    logic             col_zero;
    logic             col_one;
    logic             row_zero;
    logic             row_one;
    logic [CW-1:0]    col;
    logic [PIX_W-1:0] pix;
    logic [PIX_W-1:0] left;
  } stage_t;

  function automatic logic [WW-1:0] clamp_w(input logic [CFG_W-1:0] v);
    logic [WW-1:0] r;
    if (int'(v) < SIZE_MIN) r = WW'(SIZE_MIN);
    else if (int'(v) > MAX_WIDTH) r = WW'(MAX_WIDTH);
    else r = WW'(v);
    return r;
  endfunction

  function automatic logic [HW-1:0] clamp_h(input logic [CFG_W-1:0] v);
    logic [HW-1:0] r;
    if (int'(v) < SIZE_MIN) r = HW'(SIZE_MIN);
    else if (int'(v) > MAX_HEIGHT) r = HW'(MAX_HEIGHT);
    else r = HW'(v);
    return r;
  endfunction

  logic [WW-1:0]    width_q;
  logic [HW-1:0]    height_q;
  logic [CNT_W-1:0] count_q;
  logic [CW-1:0]    col_q;
  logic [RW-1:0]    row_q;
  logic [PIX_W-1:0] left_q;
  logic [TOTAL_W-1:0] total_q;
  logic             s1_valid_q;
  stage_t           s1_q;

  logic [1:0]            div_state_q;
  logic [STEP_W-1:0]     div_step_q;
  logic [CNT_W-1:0]      div_rem_q;
  logic [DIVIDEND_W-1:0] div_quo_q;
  logic [TOTAL_W-1:0]    div_total_q;

  logic               out_valid_q;
  logic [TOTAL_W-1:0] out_total_q;
  logic [MEAN_W-1:0]  out_mean_q;

  logic             cfg_wr;
  logic             pix_acc;
  logic             col_last;
  logic             row_last;
  logic [PIX_W-1:0] up_pix;
  logic [PIX_W-1:0] h_diff;
  logic [PIX_W-1:0] v_diff;
  logic [ADD_W-1:0] h_term;
  logic [ADD_W-1:0] v_term;
  logic [ADD_W-1:0] add;
  logic [TOTAL_W:0] sum;
  logic [TOTAL_W-1:0] sat_sum;
  logic [CNT_W:0]   div_trial;
  logic             div_fit;
  logic             out_load;

  assign cfg_i.ready   = 1'b1;
  assign cfg_wr        = cfg_i.valid;
  assign pixel_i.ready = (div_state_q == DIV_IDLE);
  assign pix_acc       = pixel_i.valid && pixel_i.ready;

  assign col_last = ((WW'(col_q) + WW'(1)) == width_q);
  assign row_last = ((HW'(row_q) + HW'(1)) == height_q);

  // Hold frame size and pixel count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= RST_W;
      height_q <= RST_H;
    end else if (cfg_wr) begin
      case (cfg_i.index)
        CFG_FRAME_WIDTH:  width_q  <= clamp_w(cfg_i.data);
        CFG_FRAME_HEIGHT: height_q <= clamp_h(cfg_i.data);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    count_q <= {{HW{1'b0}}, width_q} * {{WW{1'b0}}, height_q};
  end

  // Advance frame position and previous pixel on each request; a size write restarts the position
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      left_q <= '0;
    end else if (cfg_wr && (cfg_i.index == CFG_FRAME_WIDTH ||
                            cfg_i.index == CFG_FRAME_HEIGHT)) begin
      col_q <= '0;
      row_q <= '0;
    end else if (pix_acc) begin
      left_q <= pixel_i.pixel;
      if (col_last) begin
        col_q <= '0;
        row_q <= row_last ? '0 : row_q + RW'(1);
      end else begin
        col_q <= col_q + CW'(1);
      end
    end
  end

  // Capture the request for the accumulate stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= pix_acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pix_acc) begin
      s1_q.last     <= col_last && row_last;
      s1_q.col_zero <= (col_q == '0);
      s1_q.col_one  <= (col_q == CW'(1));
      s1_q.row_zero <= (row_q == '0);
      s1_q.row_one  <= (row_q == RW'(1));
      s1_q.col      <= col_q;
      s1_q.pix      <= pixel_i.pixel;
      s1_q.left     <= left_q;
    end
  end

  // Previous row: read ahead at accept, write back in the accumulate stage
  smdf_ram #(
    .WIDTH(PIX_W),
    .DEPTH(MAX_WIDTH)
  ) u_row_ram (
    .clk_i     (clk_i),
    .wr_en_i   (s1_valid_q),
    .wr_addr_i (s1_q.col),
    .wr_data_i (s1_q.pix),
    .rd_en_i   (pix_acc),
    .rd_addr_i (col_q),
    .rd_data_o (up_pix)
  );

  // Form the two differences: none on a mirrored border, doubled next to it
  assign h_diff = (s1_q.pix > s1_q.left) ? s1_q.pix - s1_q.left : s1_q.left - s1_q.pix;
  assign v_diff = (s1_q.pix > up_pix) ? s1_q.pix - up_pix : up_pix - s1_q.pix;

  always_comb begin
    if (s1_q.col_zero) h_term = '0;
    else if (s1_q.col_one) h_term = {1'b0, h_diff, 1'b0};
    else h_term = {2'b00, h_diff};

    if (s1_q.row_zero) v_term = '0;
    else if (s1_q.row_one) v_term = {1'b0, v_diff, 1'b0};
    else v_term = {2'b00, v_diff};
  end

  assign add     = h_term + v_term;
  assign sum     = {1'b0, total_q} + (TOTAL_W + 1)'(add);
  assign sat_sum = sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];

  // Accumulate; drop the total at frame end or restart
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= '0;
    end else if (cfg_wr && (cfg_i.index == CFG_FRAME_WIDTH ||
                            cfg_i.index == CFG_FRAME_HEIGHT)) begin
      total_q <= '0;
    end else if (s1_valid_q) begin
      total_q <= s1_q.last ? '0 : sat_sum;
    end
  end

  // Restoring divider, one quotient bit per cycle
  assign div_trial = {div_rem_q, div_quo_q[DIVIDEND_W-1]};
  assign div_fit   = (div_trial >= {1'b0, count_q});
  assign out_load  = (div_state_q == DIV_DONE) && (!out_valid_q || result_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_state_q <= DIV_IDLE;
      div_step_q  <= '0;
    end else begin
      case (div_state_q)
        DIV_IDLE: begin
          if (s1_valid_q && s1_q.last) begin
            div_state_q <= DIV_RUN;
            div_step_q  <= STEP_W'(DIVIDEND_W);
          end
        end
        DIV_RUN: begin
          div_step_q <= div_step_q - STEP_W'(1);
          if (div_step_q == STEP_W'(1)) div_state_q <= DIV_DONE;
        end
        DIV_DONE: begin
          if (out_load) div_state_q <= DIV_IDLE;
        end
        default: div_state_q <= DIV_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (div_state_q == DIV_IDLE && s1_valid_q && s1_q.last) begin
      div_rem_q   <= '0;
      div_quo_q   <= {sat_sum, {FRAC_W{1'b0}}};
      div_total_q <= sat_sum;
    end else if (div_state_q == DIV_RUN) begin
      div_rem_q <= div_fit ? CNT_W'(div_trial - {1'b0, count_q}) : div_trial[CNT_W-1:0];
      div_quo_q <= {div_quo_q[DIVIDEND_W-2:0], div_fit};
    end
  end

  // Output register: hold until the receiver takes the request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_total_q <= div_total_q;
      out_mean_q  <= div_quo_q[MEAN_W-1:0];
    end
  end

  assign result_o.valid            = out_valid_q;
  assign result_o.total_difference = out_total_q;
  assign result_o.mean_difference  = out_mean_q;

endmodule

// ===== design/smdf_checker.sv =====
`timescale 1ns / 1ps

module smdf_checker import smdf_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               pix_ready_i,
  input logic               res_valid_i,
  input logic               res_ready_i,
  input logic [TOTAL_W-1:0] res_total_i,
  input logic [MEAN_W-1:0]  res_mean_i
);

  // A stalled result holds its value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(res_total_i) && $stable(res_mean_i))
    else $error("result changed while stalled");

  // The mean never exceeds 510 per pixel (130560 with its 8 fraction bits)
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> (res_mean_i <= MEAN_W'(130560)))
    else $error("mean out of range");

  // Frames hold at least four pixels, so mean * 4 <= total * 256
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> ((TOTAL_W + 6)'(res_mean_i) <= {res_total_i, 6'd0}))
    else $error("mean larger than total allows");

  // A fresh result follows a cycle in which pixel intake was held
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_valid_i) |-> $past(!pix_ready_i))
    else $error("result appeared without divider interlock");

endmodule

bind sum_modulus_difference_focus_top smdf_checker u_smdf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .pix_ready_i (pixel_i.ready),
  .res_valid_i (result_o.valid),
  .res_ready_i (result_o.ready),
  .res_total_i (result_o.total_difference),
  .res_mean_i  (result_o.mean_difference)
);

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import smdf_pkg::*;

  localparam int unsigned SETTLE_CYCLES = 48;   // divider latency plus margin
  localparam int unsigned QUIET_LIMIT   = 2000; // cycles without any request
  localparam int unsigned RANDOM_PIXELS = 600;
  localparam int unsigned RANDOM_FRAMES = 30;
  localparam int unsigned LARGE_PIXELS  = 150;

  // Register indexes past the two real registers; writes there do nothing
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_3 = 2'd3;

  typedef enum int {TEX_NOISE, TEX_SMOOTH, TEX_FLAT} texture_e;

  typedef struct packed {
    logic [TOTAL_W-1:0] total;
    logic [MEAN_W-1:0]  mean;
  } frame_result_t;

  // Focus measure of the frame in flight plus the results still owed
  class focus_scoreboard;
    logic [CFG_W-1:0]   width_reg;
    logic [CFG_W-1:0]   height_reg;
    logic [PIX_W-1:0]   line_buf [DEF_MAX_WIDTH];
    logic [PIX_W-1:0]   prev_pixel;
    int unsigned        col;
    int unsigned        row;
    logic [TOTAL_W-1:0] sum_acc;
    frame_result_t      frame_sums[$];
    int unsigned        errors;

    function new();
      width_reg  = CFG_W'(SIZE_RESET);
      height_reg = CFG_W'(SIZE_RESET);
      foreach (line_buf[i]) line_buf[i] = '0;
      prev_pixel = '0;
      col        = 0;
      row        = 0;
      sum_acc    = '0;
      errors     = 0;
    endfunction

    function int unsigned clamp_size(int unsigned v, int unsigned hi);
      if (v < SIZE_MIN) return SIZE_MIN;
      if (v > hi) return hi;
      return v;
    endfunction

    function int unsigned frame_pixels();
      return clamp_size(width_reg, DEF_MAX_WIDTH) * clamp_size(height_reg, DEF_MAX_HEIGHT);
    endfunction

    function void report(string msg);
      $display("%0t mismatch: %s", $realtime, msg);
      errors++;
    endfunction

    // Apply a register write; either real register restarts the frame
    function void take_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      if (idx == CFG_FRAME_WIDTH || idx == CFG_FRAME_HEIGHT) begin
        if (idx == CFG_FRAME_WIDTH) width_reg = data;
        else height_reg = data;
        col     = 0;
        row     = 0;
        sum_acc = '0;
      end
    endfunction

    // Accumulate the differences of one pixel; close the frame at its end
    function void take_pixel(logic [PIX_W-1:0] p);
      int unsigned       w;
      int unsigned       h;
      int unsigned       c;
      int                d;
      longint unsigned   step;
      longint unsigned   acc;
      frame_result_t     r;
      w    = clamp_size(width_reg, DEF_MAX_WIDTH);
      h    = clamp_size(height_reg, DEF_MAX_HEIGHT);
      c    = (col >= DEF_MAX_WIDTH) ? 0 : col;
      step = 0;
      // horizontal term, mirrored at column 0 so column 1 counts twice
      if (c >= 1) begin
        d = int'(p) - int'(prev_pixel);
        if (d < 0) d = -d;
        step += (c == 1) ? 2 * d : d;
      end
      // vertical term, mirrored at row 0 so row 1 counts twice
      if (row >= 1) begin
        d = int'(p) - int'(line_buf[c]);
        if (d < 0) d = -d;
        step += (row == 1) ? 2 * d : d;
      end
      line_buf[c] = p;
      prev_pixel  = p;
      acc = longint'(sum_acc) + step;
      sum_acc = (acc > longint'(TOTAL_MAX)) ? TOTAL_MAX : acc[TOTAL_W-1:0];
      c++;
      if (c >= w) begin
        c = 0;
        row++;
        if (row >= h) begin
          acc     = sum_acc;
          acc     = (acc << FRAC_W) / (longint'(w) * longint'(h));
          r.total = sum_acc;
          r.mean  = acc[MEAN_W-1:0];
          frame_sums.push_back(r);
          row     = 0;
          sum_acc = '0;
        end
      end
      col = c;
    endfunction

    // Compare one frame result with the oldest one owed
    function void check_frame(logic [TOTAL_W-1:0] total, logic [MEAN_W-1:0] mean);
      frame_result_t want;
      if (frame_sums.size() == 0) begin
        report($sformatf("unexpected frame result total=%0d mean=%0d", total, mean));
        return;
      end
      want = frame_sums.pop_front();
      if (total !== want.total)
        report($sformatf("total_difference got %0d, want %0d", total, want.total));
      if (mean !== want.mean)
        report($sformatf("mean_difference got %0d, want %0d", mean, want.mean));
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  logic steady;
  int unsigned quiet_cycles = 0;
  focus_scoreboard board;

  smdf_pixel_if  pixel_ch ();
  smdf_result_if result_ch ();
  smdf_cfg_if    cfg_ch ();

  sum_modulus_difference_focus_top uut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .pixel_i  (pixel_ch),
    .result_o (result_ch),
    .cfg_i    (cfg_ch)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic bit take_break();
    return !steady && ($urandom_range(99) < 22);
  endfunction

  // Stall the result receiver at random
  always @(negedge clk_i) begin
    result_ch.ready <= !take_break();
  end

  // Check each accepted frame result
  always @(posedge clk_i) begin
    if (rst_ni && result_ch.valid && result_ch.ready)
      board.check_frame(result_ch.total_difference, result_ch.mean_difference);
  end

  // Abort when no request moves for too long
  always @(posedge clk_i) begin
    if ((pixel_ch.valid && pixel_ch.ready) || (cfg_ch.valid && cfg_ch.ready) ||
        (result_ch.valid && result_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[sum_modulus_difference_focus_top] ERROR");
      $finish;
    end
  end

  // Offer one pixel; returns at the falling edge after acceptance
  task automatic send_pixel(input logic [PIX_W-1:0] p);
    while (take_break()) begin
      pixel_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    pixel_ch.valid <= 1'b1;
    pixel_ch.pixel <= p;
    @(posedge clk_i);
    while (!pixel_ch.ready) @(posedge clk_i);
    board.take_pixel(p);
    @(negedge clk_i);
  endtask

  // Offer one register write; valid stays high for the caller to drop
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    while (take_break()) begin
      cfg_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    board.take_config(idx, data);
    @(negedge clk_i);
  endtask

  // Drop the pixel stream, drain owed results and let the divider finish
  task automatic settle();
    pixel_ch.valid <= 1'b0;
    while (board.frame_sums.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic configure(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
    settle();
    write_reg(CFG_FRAME_WIDTH, w);
    write_reg(CFG_FRAME_HEIGHT, h);
    cfg_ch.valid <= 1'b0;
  endtask

  // Stream count pixels of one random texture
  task automatic send_frame(input int unsigned count);
    texture_e tex;
    int       level;
    tex   = texture_e'($urandom_range(2));
    level = $urandom_range(255);
    for (int unsigned i = 0; i < count; i++) begin
      case (tex)
        TEX_NOISE: begin
          level = $urandom_range(255);
        end
        TEX_SMOOTH: begin
          level = level + int'($urandom_range(8)) - 4;
          if (level < 0) level = 0;
          if (level > 255) level = 255;
        end
        default: begin
        end
      endcase
      send_pixel(PIX_W'(level));
    end
  endtask

  initial begin
    int unsigned sent;
    int unsigned frames;
    int unsigned n;
    bit          need_cfg;
    board           = new();
    steady          = 1'b0;
    pixel_ch.valid  = 1'b0;
    pixel_ch.pixel  = '0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.index    = CFG_FRAME_WIDTH;
    cfg_ch.data     = '0;
    rst_ni          = 1'b0;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Sizes below the minimum clamp to 2x2; pixel extremes
    configure(12'd0, 12'd1);
    send_pixel(8'd0);
    send_pixel(8'd255);
    send_pixel(8'd255);
    send_pixel(8'd0);

    // Abandon a frame after two pixels; rewriting a register restarts it
    configure(12'd3, 12'd2);
    send_pixel(8'd255);
    send_pixel(8'd0);
    settle();
    write_reg(CFG_FRAME_WIDTH, 12'd3);
    cfg_ch.valid <= 1'b0;
    send_pixel(8'd10);
    send_pixel(8'd200);
    send_pixel(8'd0);
    send_pixel(8'd255);
    send_pixel(8'd128);
    send_pixel(8'd1);

    // Writes to unused indexes must not disturb the frame in flight
    send_pixel(8'd77);
    send_pixel(8'd3);
    settle();
    write_reg(CFG_UNUSED_2, 12'hfff);
    write_reg(CFG_UNUSED_3, 12'h000);
    cfg_ch.valid <= 1'b0;
    send_pixel(8'd254);
    send_pixel(8'd1);
    send_pixel(8'd90);
    send_pixel(8'd160);

    // Sizes past the maximum clamp to 2048; stream part of a wide row
    configure(12'hfff, 12'd2049);
    send_frame(LARGE_PIXELS);

    // Random frames of small sizes, with some abandoned part way
    sent     = 0;
    frames   = 0;
    need_cfg = 1'b1;
    while (sent < RANDOM_PIXELS || frames < RANDOM_FRAMES) begin
      steady = (sent < 250);
      if (need_cfg || $urandom_range(2) == 0)
        configure(CFG_W'($urandom_range(10)), CFG_W'($urandom_range(6)));
      need_cfg = 1'b0;
      n = board.frame_pixels();
      if ($urandom_range(7) == 0) begin
        n = $urandom_range(n - 1, 1);
        need_cfg = 1'b1;
      end else begin
        frames++;
      end
      send_frame(n);
      sent += n;
    end

    steady = 1'b0;
    settle();
    if (board.errors == 0) begin
      $display("[sum_modulus_difference_focus_top] OK");
    end else begin
      $display("[sum_modulus_difference_focus_top] ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/smdf_pkg.sv
design/smdf_if.sv
design/smdf_ram.sv
design/sum_modulus_difference_focus_top.sv
design/smdf_checker.sv
tb/sv/testbench.sv
